>>> src/wcv_pkg.sv
package wcv_pkg;

	localparam int CLASSES_DEF       = 9;
	localparam int HISTORY_DEPTH_DEF = 10;

	// Field layout of one input and one output transfer.
	localparam int CONF_FIELDS = 9;
	localparam int CONF_W      = 8;
	localparam int WLEN_W      = 4;
	localparam int WLEN_LSB    = CONF_FIELDS * CONF_W;
	localparam int IN_DATA_W   = 80;
	localparam int LABEL_W     = 4;
	localparam int OUT_DATA_W  = 8;

	localparam int               THR_W     = 12;
	localparam logic [THR_W-1:0] THR_RESET = 12'd205;

	typedef enum logic {
		KIND_PUSH  = 1'b0,
		KIND_QUERY = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH,
		ST_WALK,
		ST_DRAIN,
		ST_FIN
	} state_t;

endpackage

>>> src/windowed_confidence_vote_unit.sv
// Confidence-weighted sliding-window vote over the latest classifier decisions.
//
// s_axis: one transfer per item. s_axis_tuser = 0 pushes nine class confidences
// (tdata), s_axis_tuser = 1 queries the vote over the newest window_len entries.
// m_axis: one transfer per query carrying the winning label and the uncertain flag.
// cfg: a single write channel for the 12-bit vote threshold, always ready.
//
// A push produces no output and only stores a decision. A query walks W entries, where
// W is window_len clipped to the number of stored decisions (at most HISTORY_DEPTH):
// the history memory has one read port and the walk reads one entry per cycle.
// Items are handled one at a time; s_axis_tready is high only between items.
// The result sits in an output register, so the next item is taken while a result
// still waits. A query that finishes while the previous result is still held waits
// until m_axis_tready frees the register.
// Reset empties the history (fill count and write slot go to zero, the memory is
// not cleared) and loads the threshold with 205. No clearing pass is needed.
module windowed_confidence_vote_unit #(
	parameter int CLASSES       = wcv_pkg::CLASSES_DEF,
	parameter int HISTORY_DEPTH = wcv_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// conf_0 .. conf_8 (8 bits each), window_len (4 bits), zero pad
	input  logic [wcv_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// kind
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// label (4 bits), zero pad
	output logic [wcv_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// uncertain
	output logic                             m_axis_tuser,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [wcv_pkg::THR_W-1:0]        cfg_data
);

	localparam int PTR_W   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
	localparam int CMP_W   = (CNT_W > wcv_pkg::WLEN_W) ? CNT_W : wcv_pkg::WLEN_W;
	localparam int SUM_W   = $clog2(HISTORY_DEPTH * 255 + 1);
	localparam int THC_W   = (SUM_W > wcv_pkg::THR_W) ? SUM_W : wcv_pkg::THR_W;
	localparam int ENTRY_W = wcv_pkg::LABEL_W + wcv_pkg::CONF_W;
	localparam int PUSH_N  = (CLASSES < wcv_pkg::CONF_FIELDS) ? CLASSES : wcv_pkg::CONF_FIELDS;
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(HISTORY_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(HISTORY_DEPTH);

	wcv_pkg::state_t state_q, state_d;

	logic                           in_acc;
	logic                           wr_en;
	logic                           rd_en;
	logic                           out_load;
	logic                           out_free;

	logic [wcv_pkg::IN_DATA_W-1:0]  in_data_q;
	logic [wcv_pkg::THR_W-1:0]      thr_q;
	logic [PTR_W-1:0]               wp_q;
	logic [PTR_W-1:0]               rp_q;
	logic [CNT_W-1:0]               fill_q;
	logic [CNT_W-1:0]               remain_q;
	logic [CMP_W-1:0]               wl_ext;
	logic [CMP_W-1:0]               fill_ext;
	logic [CMP_W-1:0]               win_clip;

	logic [ENTRY_W-1:0]             ring_mem [HISTORY_DEPTH];
	logic [ENTRY_W-1:0]             rd_data_s1;
	logic                           rd_valid_s1;

	logic [wcv_pkg::LABEL_W-1:0]    push_cls;
	logic [wcv_pkg::CONF_W-1:0]     push_v;

	logic [SUM_W-1:0]               sums_q [CLASSES];
	logic [wcv_pkg::LABEL_W-1:0]    best_q;
	logic [SUM_W-1:0]               best_v_q;
	logic [wcv_pkg::LABEL_W-1:0]    acc_cls;
	logic [wcv_pkg::CONF_W-1:0]     acc_sc;
	logic [SUM_W-1:0]               cur_sum;
	logic [SUM_W-1:0]               new_sum;
	logic                           acc_hit;
	logic                           acc_take;

	logic                           m_valid_q;
	logic [wcv_pkg::LABEL_W-1:0]    m_label_q;
	logic                           m_unc_q;

	assign in_acc    = s_axis_tvalid & s_axis_tready;
	assign out_free  = !m_valid_q || m_axis_tready;
	assign cfg_ready = 1'b1;

	// Window length clipped to the number of stored decisions.
	assign wl_ext   = CMP_W'(s_axis_tdata[wcv_pkg::WLEN_LSB +: wcv_pkg::WLEN_W]);
	assign fill_ext = CMP_W'(fill_q);
	assign win_clip = (wl_ext < fill_ext) ? wl_ext : fill_ext;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wcv_pkg::ST_IDLE: begin
				if (in_acc) begin
					state_d = (s_axis_tuser == wcv_pkg::KIND_QUERY) ? wcv_pkg::ST_WALK
						: wcv_pkg::ST_PUSH;
				end
			end
			wcv_pkg::ST_PUSH: state_d = wcv_pkg::ST_IDLE;
			wcv_pkg::ST_WALK: begin
				if (remain_q == '0) state_d = wcv_pkg::ST_DRAIN;
			end
			wcv_pkg::ST_DRAIN: state_d = wcv_pkg::ST_FIN;
			wcv_pkg::ST_FIN: begin
				if (out_free) state_d = wcv_pkg::ST_IDLE;
			end
			default: state_d = wcv_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		wr_en         = 1'b0;
		rd_en         = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			wcv_pkg::ST_IDLE:  s_axis_tready = 1'b1;
			wcv_pkg::ST_PUSH:  wr_en = 1'b1;
			wcv_pkg::ST_WALK:  rd_en = (remain_q != '0);
			wcv_pkg::ST_DRAIN: ;
			wcv_pkg::ST_FIN:   out_load = out_free;
			default: ;
		endcase
	end

	// First class with the largest confidence among the arriving fields.
	always_comb begin
		push_cls = '0;
		push_v   = in_data_q[wcv_pkg::CONF_W-1:0];
		for (int i = 1; i < PUSH_N; i++) begin
			if (in_data_q[i*wcv_pkg::CONF_W +: wcv_pkg::CONF_W] > push_v) begin
				push_v   = in_data_q[i*wcv_pkg::CONF_W +: wcv_pkg::CONF_W];
				push_cls = wcv_pkg::LABEL_W'(i);
			end
		end
	end

	// Pushes and walks never overlap, so a read never meets a pending write.
	always_ff @(posedge clk) begin
		if (wr_en) ring_mem[wp_q] <= {push_cls, push_v};
		if (rd_en) rd_data_s1 <= ring_mem[rp_q];
	end

	assign acc_cls = rd_data_s1[ENTRY_W-1 -: wcv_pkg::LABEL_W];
	assign acc_sc  = rd_data_s1[wcv_pkg::CONF_W-1:0];

	always_comb begin
		cur_sum = '0;
		acc_hit = 1'b0;
		for (int i = 0; i < CLASSES; i++) begin
			if (acc_cls == wcv_pkg::LABEL_W'(i)) begin
				cur_sum = sums_q[i];
				acc_hit = 1'b1;
			end
		end
	end

	assign new_sum = cur_sum + SUM_W'(acc_sc);

	// Sums only grow, so the running leader is kept as each entry is added.
	// On a tie the lower class index wins.
	assign acc_take = rd_valid_s1 && acc_hit &&
		((new_sum > best_v_q) || ((new_sum == best_v_q) && (acc_cls < best_q)));

	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int i = 0; i < CLASSES; i++) sums_q[i] <= '0;
			best_q   <= '0;
			best_v_q <= '0;
		end else if (rd_valid_s1) begin
			for (int i = 0; i < CLASSES; i++) begin
				if (acc_cls == wcv_pkg::LABEL_W'(i)) sums_q[i] <= new_sum;
			end
			if (acc_take) begin
				best_q   <= acc_cls;
				best_v_q <= new_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) in_data_q <= s_axis_tdata;
		if (out_load) begin
			m_label_q <= best_q;
			m_unc_q   <= (THC_W'(best_v_q) < THC_W'(thr_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wcv_pkg::ST_IDLE;
			thr_q       <= wcv_pkg::THR_RESET;
			wp_q        <= '0;
			rp_q        <= '0;
			fill_q      <= '0;
			remain_q    <= '0;
			rd_valid_s1 <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= rd_en;
			if (cfg_valid) thr_q <= cfg_data;
			if (in_acc && (s_axis_tuser == wcv_pkg::KIND_QUERY)) begin
				rp_q     <= (wp_q == '0) ? LAST_SLOT : wp_q - 1'b1;
				remain_q <= CNT_W'(win_clip);
			end else if (rd_en) begin
				rp_q     <= (rp_q == '0) ? LAST_SLOT : rp_q - 1'b1;
				remain_q <= remain_q - 1'b1;
			end
			if (wr_en) begin
				wp_q <= (wp_q == LAST_SLOT) ? '0 : wp_q + 1'b1;
				if (fill_q != FULL_CNT) fill_q <= fill_q + 1'b1;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(wcv_pkg::OUT_DATA_W - wcv_pkg::LABEL_W){1'b0}}, m_label_q};
	assign m_axis_tuser  = m_unc_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_CNT)
		else $error("fill count beyond history depth");

	a_read_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> (state_q == wcv_pkg::ST_WALK || state_q == wcv_pkg::ST_DRAIN))
		else $error("history read data arrived outside a query walk");

	a_push_advances: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wcv_pkg::ST_PUSH |=> wp_q != $past(wp_q))
		else $error("write slot did not advance after a push");

	a_fin_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wcv_pkg::ST_FIN && !out_free) |=> (state_q == wcv_pkg::ST_FIN && m_valid_q))
		else $error("query result overran a held output transfer");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q) == wcv_pkg::ST_FIN)
		else $error("output became valid without a finished query");

endmodule

>>> test/testbench.sv
module testbench;

	localparam int NCLASS      = wcv_pkg::CLASSES_DEF;
	localparam int DEPTH       = wcv_pkg::HISTORY_DEPTH_DEF;
	localparam int CONF_BITS   = wcv_pkg::CONF_W;
	localparam int WLEN_BITS   = wcv_pkg::WLEN_W;
	localparam int LABEL_BITS  = wcv_pkg::LABEL_W;
	localparam int THR_BITS    = wcv_pkg::THR_W;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 250;
	localparam int PHASE_ITEMS = 175;

	typedef struct {
		wcv_pkg::kind_t                                   kind;
		logic [wcv_pkg::CONF_FIELDS-1:0][CONF_BITS-1:0] conf;
		logic [WLEN_BITS-1:0]                             wlen;
	} vote_item_t;

	typedef struct {
		logic [LABEL_BITS-1:0] label;
		logic                  uncertain;
	} vote_result_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [wcv_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                           s_axis_tuser = 1'b0;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [wcv_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic                           m_axis_tuser;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [THR_BITS-1:0]            cfg_data = '0;

	// Expected-side copy of the block state.
	logic [LABEL_BITS-1:0] hist_class [DEPTH];
	logic [CONF_BITS-1:0]  hist_score [DEPTH];
	int                    hist_fill = 0;
	int                    hist_slot = 0;
	logic [THR_BITS-1:0]   vote_thr = wcv_pkg::THR_RESET;

	vote_item_t   pending [$];
	vote_result_t votes_due [$];
	int           items_queued = 0;
	int           items_taken = 0;
	int           results_seen = 0;
	int           vote_errors = 0;
	logic         in_acc = 1'b0;
	logic         calm = 1'b0;
	int           gap_left = 0;
	int           stall_left = 0;
	int           hold_left = 0;
	logic         hold_done = 1'b0;
	int           quiet = 0;

	windowed_confidence_vote_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic history_step(input logic kind_bit,
			input logic [wcv_pkg::IN_DATA_W-1:0] data);
		int           best;
		int unsigned  best_v;
		int unsigned  n;
		int           slot;
		int           i;
		int unsigned  sums [NCLASS];
		vote_result_t r;
		if (wcv_pkg::kind_t'(kind_bit) == wcv_pkg::KIND_PUSH) begin
			best = 0;
			best_v = 32'(data[CONF_BITS-1:0]);
			for (i = 1; i < NCLASS; i++) begin
				if (data[i*CONF_BITS +: CONF_BITS] > best_v) begin
					best_v = 32'(data[i*CONF_BITS +: CONF_BITS]);
					best = i;
				end
			end
			hist_class[hist_slot] = LABEL_BITS'(best);
			hist_score[hist_slot] = CONF_BITS'(best_v);
			hist_slot = (hist_slot == DEPTH - 1) ? 0 : hist_slot + 1;
			if (hist_fill < DEPTH)
				hist_fill++;
		end else begin
			n = 32'(data[wcv_pkg::WLEN_LSB +: WLEN_BITS]);
			if (n > unsigned'(hist_fill))
				n = unsigned'(hist_fill);
			for (i = 0; i < NCLASS; i++)
				sums[i] = 0;
			// Walk back from the newest entry.
			for (i = 0; i < n; i++) begin
				slot = (hist_slot + 2 * DEPTH - 1 - i) % DEPTH;
				sums[hist_class[slot]] += 32'(hist_score[slot]);
			end
			best = 0;
			best_v = sums[0];
			for (i = 1; i < NCLASS; i++) begin
				if (sums[i] > best_v) begin
					best_v = sums[i];
					best = i;
				end
			end
			r.label = LABEL_BITS'(best);
			r.uncertain = (best_v < 32'(vote_thr));
			votes_due.push_back(r);
		end
	endtask

	task automatic note_error(input string msg);
		vote_errors++;
		if (vote_errors <= 10)
			$display("mismatch: %s", msg);
	endtask

	// Input acceptance, prediction, result checking.
	always @(posedge clk) begin
		vote_result_t want;
		in_acc <= s_axis_tvalid && s_axis_tready;
		if (cfg_valid && cfg_ready)
			vote_thr = cfg_data;
		if (s_axis_tvalid && s_axis_tready) begin
			history_step(s_axis_tuser, s_axis_tdata);
			items_taken++;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (votes_due.size() == 0) begin
				note_error($sformatf("unexpected result label=%0d uncertain=%0d",
					m_axis_tdata[LABEL_BITS-1:0], m_axis_tuser));
			end else begin
				want = votes_due.pop_front();
				if (m_axis_tdata[LABEL_BITS-1:0] !== want.label ||
						m_axis_tuser !== want.uncertain)
					note_error($sformatf(
						"result %0d: expected label=%0d uncertain=%0d, got label=%0d uncertain=%0d",
						results_seen, want.label, want.uncertain,
						m_axis_tdata[LABEL_BITS-1:0], m_axis_tuser));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Sender: holds an item until its transfer, with random gaps between items.
	always @(negedge clk) begin
		vote_item_t                    nx;
		logic                          nv;
		logic [wcv_pkg::IN_DATA_W-1:0] word;
		if (arst_n) begin
			nv = s_axis_tvalid && !in_acc;
			if (!nv) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending.size() > 0) begin
					if (!calm && $urandom_range(0, 5) == 0) begin
						gap_left = $urandom_range(1, 6) - 1;
					end else begin
						nx = pending.pop_front();
						word = '0;
						word[wcv_pkg::WLEN_LSB-1:0] = nx.conf;
						word[wcv_pkg::WLEN_LSB +: WLEN_BITS] = nx.wlen;
						s_axis_tdata <= word;
						s_axis_tuser <= nx.kind;
						nv = 1'b1;
					end
				end
			end
			s_axis_tvalid <= nv;
		end
	end

	// Receiver: random stalls, plus one long hold-off that fills the block up.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (!hold_done && results_seen >= 40) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(1, 6) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	function automatic vote_item_t flat_push(input logic [CONF_BITS-1:0] level);
		vote_item_t it;
		int         i;
		it.kind = wcv_pkg::KIND_PUSH;
		it.wlen = WLEN_BITS'($urandom);
		for (i = 0; i < wcv_pkg::CONF_FIELDS; i++)
			it.conf[i] = level;
		return it;
	endfunction

	function automatic vote_item_t vote_query(input logic [WLEN_BITS-1:0] w);
		vote_item_t it;
		int         i;
		it.kind = wcv_pkg::KIND_QUERY;
		it.wlen = w;
		for (i = 0; i < wcv_pkg::CONF_FIELDS; i++)
			it.conf[i] = CONF_BITS'($urandom);
		return it;
	endfunction

	function automatic vote_item_t random_push();
		vote_item_t           it;
		logic [CONF_BITS-1:0] corner_vals [6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
		int                   mode, hot, twin, i;
		it = flat_push(8'd0);
		mode = $urandom_range(0, 3);
		for (i = 0; i < wcv_pkg::CONF_FIELDS; i++) begin
			case (mode)
				0: it.conf[i] = CONF_BITS'($urandom);
				1: it.conf[i] = corner_vals[$urandom_range(0, 5)];
				default: it.conf[i] = CONF_BITS'($urandom_range(0, 100));
			endcase
		end
		hot = $urandom_range(0, wcv_pkg::CONF_FIELDS - 1);
		twin = $urandom_range(0, wcv_pkg::CONF_FIELDS - 1);
		if (mode == 2) begin
			it.conf[hot] = CONF_BITS'($urandom_range(150, 255));
		end else if (mode == 3) begin
			// Two classes may share the top confidence, the lower index must then win.
			it.conf[hot] = CONF_BITS'($urandom_range(101, 255));
			it.conf[twin] = it.conf[hot];
		end
		return it;
	endfunction

	function automatic vote_item_t random_item();
		if ($urandom_range(0, 99) < 55)
			return random_push();
		if ($urandom_range(0, 9) == 0)
			return vote_query(WLEN_BITS'($urandom_range(DEPTH + 1, 15)));
		return vote_query(WLEN_BITS'($urandom_range(0, DEPTH)));
	endfunction

	task automatic send(input vote_item_t it);
		pending.push_back(it);
		items_queued++;
	endtask

	// Wait until every item has been taken and every result checked, then let
	// the block settle for longer than a full query takes.
	task automatic drain();
		while (items_taken != items_queued || votes_due.size() != 0)
			@(negedge clk);
		repeat (3 * (DEPTH + 4)) @(negedge clk);
	endtask

	task automatic write_threshold(input logic [THR_BITS-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		vote_item_t          it;
		logic [THR_BITS-1:0] thr_plan [8];
		int                  p, n;
		thr_plan = '{12'd1, 12'd255, 12'd256, 12'd1024, 12'd0, 12'd205, 12'd2560, 12'd0};
		thr_plan[4] = THR_BITS'($urandom_range(0, 2560));

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Empty history, reset threshold.
		send(vote_query(0));
		send(vote_query(15));
		send(flat_push(8'd0));
		send(flat_push(8'd255));
		it = flat_push(8'd254);
		it.conf[8] = 8'd255;
		send(it);
		it = flat_push(8'd10);
		it.conf[3] = 8'd200;
		it.conf[5] = 8'd200;
		send(it);
		send(vote_query(2));
		send(vote_query(15));
		// A sum equal to the threshold is certain, one below is not.
		it = flat_push(8'd0);
		it.conf[4] = 8'd205;
		send(it);
		send(vote_query(1));
		it = flat_push(8'd0);
		it.conf[6] = 8'd204;
		send(it);
		send(vote_query(1));
		for (n = 0; n < 8; n++)
			send(random_push());
		send(vote_query(10));
		send(vote_query(11));
		send(vote_query(9));
		drain();

		write_threshold(12'd0);
		send(vote_query(0));
		send(vote_query(10));
		drain();

		write_threshold(12'd2560);
		send(vote_query(10));
		send(vote_query(0));
		drain();

		for (p = 0; p < 8; p++) begin
			write_threshold(thr_plan[p]);
			calm = (p == 7);
			for (n = 0; n < PHASE_ITEMS; n++)
				send(random_item());
			drain();
		end

		if (vote_errors == 0 && votes_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
